[rtl/core/rtdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdp_pkg
// Shared constants, types and the reply byte table of the RPC-with-TLS probe
// detector.
// ----------------------------------------------------------------------------
package rtdp_pkg;

  localparam int unsigned BufferBytes = 16384;
  localparam int unsigned CountW      = $clog2(BufferBytes + 1);

  // Byte positions in the first record of the stream
  localparam int unsigned MarkerEnd   = 3;
  localparam int unsigned XidEnd      = 7;
  localparam int unsigned AuthFirst   = 28;
  localparam int unsigned FlavorLow   = 31;
  localparam int unsigned ProbeBytes  = 44;
  localparam int unsigned MarkerBytes = 4;

  localparam logic [7:0] AuthFlavorTls = 8'd7;

  localparam int unsigned ReplyBytes = 36;
  localparam int unsigned ReplyIdxW  = $clog2(ReplyBytes);
  localparam logic [ReplyIdxW-1:0] ReplyLastIdx = ReplyIdxW'(ReplyBytes - 1);

  typedef enum logic [1:0] {
    VERDICT_WAIT  = 2'd0,
    VERDICT_PROBE = 2'd1,
    VERDICT_PASS  = 2'd2
  } verdict_e;

  // Evaluation outcome of one accepted beat
  typedef struct packed {
    logic     report;  // one result beat with the verdict
    logic     reply;   // start the STARTTLS reply
    verdict_e verdict;
  } rtdp_eval_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] verdict;
    logic       last;
  } rtdp_res_t;

  // STARTTLS reply: record marker, xid echo, REPLY/ACCEPTED, flavor 0
  // verifier carrying "STARTTLS", SUCCESS
  function automatic logic [7:0] reply_byte(input logic [ReplyIdxW-1:0] idx,
                                            input logic [31:0]          xid);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      6'd0:    b = 8'h80;
      6'd3:    b = 8'h20;
      6'd4:    b = xid[31:24];
      6'd5:    b = xid[23:16];
      6'd6:    b = xid[15:8];
      6'd7:    b = xid[7:0];
      6'd11:   b = 8'h01;
      6'd23:   b = 8'h08;
      6'd24:   b = 8'h53; // S
      6'd25:   b = 8'h54; // T
      6'd26:   b = 8'h41; // A
      6'd27:   b = 8'h52; // R
      6'd28:   b = 8'h54; // T
      6'd29:   b = 8'h54; // T
      6'd30:   b = 8'h4C; // L
      6'd31:   b = 8'h53; // S
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/rtdp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdp_in_if / rtdp_out_if
// Valid/ready channels for received stream bytes and for result beats.
// ----------------------------------------------------------------------------
interface rtdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface rtdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [1:0] verdict;
  logic       last;

  modport source (output valid, output out_byte, output byte_valid,
                  output verdict, output last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input verdict, input last, output ready);
endinterface

[rtl/core/rtdp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdp_parser
// Counts stream bytes, captures record marker and xid, checks the credential
// and verifier words and gives the sticky verdict at each chunk end.
// ----------------------------------------------------------------------------
module rtdp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          in_byte_i,
  input  logic                chunk_end_i,
  output rtdp_pkg::rtdp_eval_t eval_o,
  output logic [31:0]         xid_o
);

  logic [rtdp_pkg::CountW-1:0] count_q, count_d;
  logic [23:0]                 shift_q, shift_d;
  logic [31:0]                 xid_q, xid_d;
  logic [30:0]                 len_q, len_d;
  logic                        lastfrag_q, lastfrag_d;
  logic                        match_q, match_d;
  rtdp_pkg::verdict_e          decision_q, decision_d;

  logic                        full;
  logic                        take_byte;
  logic [31:0]                 word;
  logic [7:0]                  expected;
  rtdp_pkg::verdict_e          verdict_now;
  logic [rtdp_pkg::CountW-1:0] body_len;

  assign full      = (count_q == rtdp_pkg::CountW'(rtdp_pkg::BufferBytes));
  assign take_byte = take_i && !full;
  assign word      = {shift_q, in_byte_i};
  assign expected  = (count_q == rtdp_pkg::CountW'(rtdp_pkg::FlavorLow))
                     ? rtdp_pkg::AuthFlavorTls : 8'h00;

  always_comb begin
    count_d    = count_q;
    shift_d    = shift_q;
    xid_d      = xid_q;
    len_d      = len_q;
    lastfrag_d = lastfrag_q;
    match_d    = match_q;
    if (take_byte) begin
      count_d = count_q + rtdp_pkg::CountW'(1);
      shift_d = word[23:0];
      if (count_q == rtdp_pkg::CountW'(rtdp_pkg::MarkerEnd)) begin
        lastfrag_d = word[31];
        len_d      = word[30:0];
      end else if (count_q == rtdp_pkg::CountW'(rtdp_pkg::XidEnd)) begin
        xid_d = word;
      end
      if (count_q >= rtdp_pkg::CountW'(rtdp_pkg::AuthFirst) &&
          count_q <  rtdp_pkg::CountW'(rtdp_pkg::ProbeBytes) &&
          in_byte_i != expected) begin
        match_d = 1'b0;
      end
    end
  end

  // Verdict from the state as it stands after this byte
  assign body_len = count_d - rtdp_pkg::CountW'(rtdp_pkg::MarkerBytes);

  always_comb begin
    if (count_d < rtdp_pkg::CountW'(rtdp_pkg::MarkerBytes)) begin
      verdict_now = rtdp_pkg::VERDICT_WAIT;
    end else if (!lastfrag_d) begin
      verdict_now = rtdp_pkg::VERDICT_PASS;
    end else if (count_d < rtdp_pkg::CountW'(rtdp_pkg::ProbeBytes) ||
                 31'(body_len) < len_d) begin
      verdict_now = rtdp_pkg::VERDICT_WAIT;
    end else if (match_d && count_d == rtdp_pkg::CountW'(rtdp_pkg::ProbeBytes)) begin
      verdict_now = rtdp_pkg::VERDICT_PROBE;
    end else begin
      verdict_now = rtdp_pkg::VERDICT_PASS;
    end
  end

  always_comb begin
    decision_d     = decision_q;
    eval_o.report  = 1'b0;
    eval_o.reply   = 1'b0;
    eval_o.verdict = decision_q;
    if (take_i && chunk_end_i) begin
      if (decision_q == rtdp_pkg::VERDICT_WAIT) begin
        decision_d     = verdict_now;
        eval_o.verdict = verdict_now;
        if (verdict_now == rtdp_pkg::VERDICT_PROBE) begin
          eval_o.reply = 1'b1;
        end else begin
          eval_o.report = 1'b1;
        end
      end else begin
        eval_o.report = 1'b1;
      end
    end
  end

  assign xid_o = xid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      shift_q    <= '0;
      xid_q      <= '0;
      len_q      <= '0;
      lastfrag_q <= 1'b0;
      match_q    <= 1'b1;
      decision_q <= rtdp_pkg::VERDICT_WAIT;
    end else begin
      count_q    <= count_d;
      shift_q    <= shift_d;
      xid_q      <= xid_d;
      len_q      <= len_d;
      lastfrag_q <= lastfrag_d;
      match_q    <= match_d;
      decision_q <= decision_d;
    end
  end

endmodule

[rtl/core/rpc_tls_probe_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_tls_probe_detector_unit
// Detects the RPC-with-TLS probe (auth flavor 7) at the head of a
// record-marked ONC RPC byte stream and answers it with the STARTTLS reply.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle, but the input is held off while the
// reply streams out or the skid stage is full. A beat without chunk_end
// gives no result; a chunk end gives one result beat with the verdict
// (0 waiting, 1 probe, 2 pass-through), except the chunk end that first
// recognizes the probe, which gives the 36 reply beats one per cycle while
// the output takes them, the xid echoed in bytes 4 to 7. A skid stage
// ahead of the output keeps the input flowing while one result waits in
// the output register. Verdicts are sticky; bytes past 16384 are dropped.
// ----------------------------------------------------------------------------
module rpc_tls_probe_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtdp_in_if.sink    in_i,
  rtdp_out_if.source out_o
);

  rtdp_pkg::rtdp_eval_t        eval;
  logic [31:0]                 xid;
  logic                        in_ready;
  logic                        accept;

  logic                        reply_busy_q, reply_busy_d;
  logic [rtdp_pkg::ReplyIdxW-1:0] reply_idx_q, reply_idx_d;

  logic                        push_valid;
  rtdp_pkg::rtdp_res_t         push_res;
  logic                        up_ready;

  logic                        out_valid_q, out_valid_d;
  rtdp_pkg::rtdp_res_t         out_q, out_d;
  logic                        skid_valid_q, skid_valid_d;
  rtdp_pkg::rtdp_res_t         skid_q, skid_d;

  assign up_ready = !skid_valid_q;
  assign in_ready = !reply_busy_q && up_ready;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  rtdp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept),
    .in_byte_i   (in_i.in_byte),
    .chunk_end_i (in_i.chunk_end),
    .eval_o      (eval),
    .xid_o       (xid)
  );

  // Result source: reply sequencer first, else the verdict beat
  always_comb begin
    reply_busy_d = reply_busy_q;
    reply_idx_d  = reply_idx_q;
    push_valid   = 1'b0;
    push_res     = '0;
    if (reply_busy_q) begin
      push_valid          = 1'b1;
      push_res.out_byte   = rtdp_pkg::reply_byte(reply_idx_q, xid);
      push_res.byte_valid = 1'b1;
      push_res.verdict    = rtdp_pkg::VERDICT_PROBE;
      push_res.last       = (reply_idx_q == rtdp_pkg::ReplyLastIdx);
      if (up_ready) begin
        if (reply_idx_q == rtdp_pkg::ReplyLastIdx) begin
          reply_busy_d = 1'b0;
          reply_idx_d  = '0;
        end else begin
          reply_idx_d = reply_idx_q + rtdp_pkg::ReplyIdxW'(1);
        end
      end
    end else if (accept && eval.reply) begin
      reply_busy_d = 1'b1;
      reply_idx_d  = '0;
    end else if (accept && eval.report) begin
      push_valid       = 1'b1;
      push_res.verdict = eval.verdict;
      push_res.last    = 1'b1;
    end
  end

  // Output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_o.ready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_valid;
        out_d       = push_res;
      end
    end else if (push_valid && up_ready) begin
      skid_valid_d = 1'b1;
      skid_d       = push_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.verdict    = out_q.verdict;
  assign out_o.last       = out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_busy_q <= 1'b0;
      reply_idx_q  <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      reply_busy_q <= reply_busy_d;
      reply_idx_q  <= reply_idx_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // A held beat in the skid stage implies the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  // No input beat is taken while the reply streams out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_busy_q |-> !in_i.ready)
    else $error("input taken during reply");

  // A reply always starts at its first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reply_busy_q) |-> reply_idx_q == '0)
    else $error("reply started mid-sequence");

  // Reply bytes only ever carry the probe verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.byte_valid) |-> out_q.verdict == rtdp_pkg::VERDICT_PROBE)
    else $error("reply byte without probe verdict");

endmodule

[verif/rpc_tls_probe_detector_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_tls_probe_detector_unit_tb
// Streams one record-marked RPC head into the probe detector, chosen at
// random among a clean TLS probe and several pass-through shapes, then a
// tail of random bytes. A scoreboard tracks the stream state beat by beat
// and checks every result beat.
// ----------------------------------------------------------------------------
module rpc_tls_probe_detector_unit_tb;
  import rtdp_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned TailBeats  = 120;

  localparam logic [7:0] StarttlsReply [ReplyBytes] = '{
    8'h80, 8'h00, 8'h00, 8'h20,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h08,
    8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h54, 8'h4C, 8'h53,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum int unsigned {
    HEAD_PROBE,
    HEAD_NO_LAST_FRAG,
    HEAD_BAD_AUTH,
    HEAD_LONG_RECORD,
    HEAD_LATE_END
  } head_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_beat_t;

  class probe_verdict_sb;
    int unsigned held_bytes;
    logic [31:0] last_word;
    logic [31:0] xid;
    logic [30:0] rec_len;
    logic        last_frag;
    logic        auth_ok;
    verdict_e    sticky;
    rtdp_res_t   awaited[$];
    int unsigned mismatches;

    function new();
      held_bytes = 0;
      last_word  = '0;
      xid        = '0;
      rec_len    = '0;
      last_frag  = 1'b0;
      auth_ok    = 1'b1;
      sticky     = VERDICT_WAIT;
      mismatches = 0;
    endfunction

    function verdict_e judge();
      if (held_bytes < MarkerBytes) return VERDICT_WAIT;
      if (!last_frag) return VERDICT_PASS;
      if (held_bytes < ProbeBytes || (held_bytes - MarkerBytes) < rec_len)
        return VERDICT_WAIT;
      if (auth_ok && held_bytes == ProbeBytes) return VERDICT_PROBE;
      return VERDICT_PASS;
    endfunction

    // Advance the stream state by one accepted beat and queue its results
    function void absorb(logic [7:0] b, logic fin);
      int unsigned pos;
      logic [7:0] want;
      rtdp_res_t r;
      pos = held_bytes;
      if (pos < BufferBytes) begin
        last_word = {last_word[23:0], b};
        if (pos == MarkerEnd) begin
          last_frag = last_word[31];
          rec_len   = last_word[30:0];
        end else if (pos == XidEnd) begin
          xid = last_word;
        end
        want = (pos == FlavorLow) ? AuthFlavorTls : 8'h00;
        if (pos >= AuthFirst && pos < ProbeBytes && b != want) auth_ok = 1'b0;
        held_bytes = pos + 1;
      end
      if (!fin) return;
      if (sticky == VERDICT_WAIT) begin
        sticky = judge();
        if (sticky == VERDICT_PROBE) begin
          for (int k = 0; k < ReplyBytes; k++) begin
            r.out_byte = StarttlsReply[k];
            if (k >= 4 && k < 8) r.out_byte = xid[8*(7-k) +: 8];
            r.byte_valid = 1'b1;
            r.verdict    = VERDICT_PROBE;
            r.last       = (k == ReplyBytes - 1);
            awaited.push_back(r);
          end
          return;
        end
      end
      r.out_byte   = 8'h00;
      r.byte_valid = 1'b0;
      r.verdict    = sticky;
      r.last       = 1'b1;
      awaited.push_back(r);
    endfunction

    function void match_result(rtdp_res_t got);
      rtdp_res_t want;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: out_byte %0h verdict %0d",
               got.out_byte, got.verdict);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
        mismatches++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rtdp_in_if  in_ch ();
  rtdp_out_if out_ch ();

  rpc_tls_probe_detector_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  probe_verdict_sb sb = new();
  stream_beat_t    stream_q[$];
  int unsigned     burst_left = 0;
  logic [15:0]     stall_pat = 16'hFFFF;
  int unsigned     pat_age = 0;
  int unsigned     quiet = 0;

  // Receiver: rotate a stall pattern, swap it for a fresh one now and then
  always @(negedge clk_i) begin
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_pat <= 16'hFFFF;
        end
        default: begin
          stall_pat <= 16'($urandom()) | 16'h0001;
        end
      endcase
      pat_age <= $urandom_range(20, 150);
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
      pat_age   <= pat_age - 1;
    end
    out_ch.ready <= stall_pat[0];
  end

  always @(posedge clk_i) begin : result_mon
    rtdp_res_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.out_byte   = out_ch.out_byte;
      got.byte_valid = out_ch.byte_valid;
      got.verdict    = out_ch.verdict;
      got.last       = out_ch.last;
      sb.match_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Build the head of one record; the kind decides which verdict it reaches
  task automatic queue_head();
    head_kind_e  kind;
    int unsigned rec_len;
    int unsigned total;
    int unsigned flip_pos;
    int unsigned i;
    logic [31:0] marker;
    logic [31:0] xid;
    stream_beat_t bt;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: kind = HEAD_PROBE;
      4:          kind = HEAD_NO_LAST_FRAG;
      5:          kind = HEAD_BAD_AUTH;
      6:          kind = HEAD_LONG_RECORD;
      default:    kind = HEAD_LATE_END;
    endcase
    rec_len  = $urandom_range(0, ProbeBytes - MarkerBytes);
    marker   = {1'b1, 31'(rec_len)};
    xid      = $urandom();
    total    = ProbeBytes;
    flip_pos = $urandom_range(AuthFirst, ProbeBytes - 1);
    case (kind)
      HEAD_NO_LAST_FRAG: begin
        marker = $urandom() & 32'h7FFF_FFFF;
      end
      HEAD_LONG_RECORD: begin
        rec_len = $urandom_range(ProbeBytes - MarkerBytes + 1, 120);
        marker  = {1'b1, 31'(rec_len)};
        total   = rec_len + MarkerBytes + $urandom_range(0, 8);
      end
      HEAD_LATE_END: begin
        total = ProbeBytes + $urandom_range(1, 6);
      end
      default: begin
      end
    endcase
    for (i = 0; i < total; i++) begin
      if (i < MarkerBytes) bt.data = marker[31 - 8*i -: 8];
      else if (i <= XidEnd) bt.data = xid[31 - 8*(i - MarkerBytes) -: 8];
      else if (i == XidEnd + 1) bt.data = 8'hFF;
      else if (i == XidEnd + 2) bt.data = 8'h00;
      else if (i < AuthFirst) bt.data = 8'($urandom());
      else if (i < ProbeBytes) bt.data = (i == FlavorLow) ? AuthFlavorTls : 8'h00;
      else bt.data = 8'($urandom());
      if (kind == HEAD_BAD_AUTH && i == flip_pos) bt.data ^= 8'($urandom_range(1, 255));

      bt.fin = ($urandom_range(0, 4) == 0);
      if (i < MarkerBytes || i == total - 1) bt.fin = 1'b1;
      if (i == ProbeBytes - 1) bt.fin = (kind != HEAD_LATE_END);
      if (kind == HEAD_LONG_RECORD && i == rec_len + MarkerBytes - 1) bt.fin = 1'b1;
      stream_q.push_back(bt);
    end
  endtask

  task automatic queue_tail();
    stream_beat_t bt;
    for (int i = 0; i < TailBeats; i++) begin
      bt.data = 8'($urandom());
      bt.fin  = ($urandom_range(0, 2) == 0);
      stream_q.push_back(bt);
    end
  endtask

  // Send queued beats in bursts with random gaps; called and left at negedge
  task automatic play_stream();
    stream_beat_t bt;
    int unsigned gap;
    while (stream_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 12);
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      bt = stream_q.pop_front();
      in_ch.valid     <= 1'b1;
      in_ch.in_byte   <= bt.data;
      in_ch.chunk_end <= bt.fin;
      do @(posedge clk_i); while (!in_ch.ready);
      sb.absorb(bt.data, bt.fin);
      burst_left--;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.chunk_end = 1'b0;
    out_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_head();
    play_stream();
    // hold the sender until the head's verdicts are all out
    wait_drained();
    queue_tail();
    play_stream();
    wait_drained();
    repeat (64) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rtdp_pkg.sv
rtl/core/rtdp_if.sv
rtl/core/rtdp_parser.sv
rtl/core/rpc_tls_probe_detector_unit.sv
verif/rpc_tls_probe_detector_unit_tb.sv
